[hw/rtl/line_follow_pid_steering_assert.svh]
// Assertion macros used by the steering block controller
`ifndef LINE_FOLLOW_PID_STEERING_ASSERT_SVH
`define LINE_FOLLOW_PID_STEERING_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define LFPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define LFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lfps_pkg.sv]
// Types and constants of the line-follower steering block
`default_nettype none

package lfps_pkg;

    localparam int SENSOR_W   = 8;
    localparam int N_SENSORS  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int GAIN_W     = 24;
    localparam int SPEED_W    = 16;
    localparam int OFFSET_W   = 12;
    localparam int ERR_W      = 13;
    localparam int DIFF_W     = 14;
    localparam int ESUM_W     = 32;
    localparam int SSUM_W     = 11;
    localparam int DVD_W      = 19;
    localparam int QUOT_W     = 11;
    localparam int DIV_CNT_W  = 5;
    localparam int PROD_W     = 57;
    localparam int ACC_W      = 58;
    localparam int CORR_W     = 16;
    localparam int COUNT_W    = 3;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST   = 5'd18;
    localparam logic [SENSOR_W-1:0]  DARK_LEVEL = 8'd102;
    localparam logic [SPEED_W-1:0]   SPEED_MAX  = 16'hFF00;
    localparam logic [ACC_W-1:0]     RND_HALF   = 58'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_DT_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_DT_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_POINT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW   = 3'd6;

    localparam logic [GAIN_W-1:0]   RST_KP_GAIN    = 24'd78643;
    localparam logic [GAIN_W-1:0]   RST_KI_DT_GAIN = 24'd26;
    localparam logic [GAIN_W-1:0]   RST_KD_DT_GAIN = 24'd78643;
    localparam logic [SPEED_W-1:0]  RST_BASE_SPEED = 16'd1280;
    localparam logic [OFFSET_W-1:0] RST_SET_POINT  = 12'd0;
    localparam logic [SENSOR_W-1:0] RST_BAND_HIGH  = 8'd128;
    localparam logic [SENSOR_W-1:0] RST_BAND_LOW   = 8'd51;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ERR,
        ST_MUL,
        ST_ACC,
        ST_RND,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        MUL_P,
        MUL_I,
        MUL_D
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     err_upd;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_en;
        logic     rnd;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_sts;

endpackage

`default_nettype wire

[hw/rtl/lfps_if.sv]
// Item and result channel interfaces of the steering block
`default_nettype none

interface lfps_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] sensor_0;
    logic [7:0] sensor_1;
    logic [7:0] sensor_2;
    logic [7:0] sensor_3;
    logic [7:0] sensor_4;
    logic       clear_history;

    modport source (
        output valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4, clear_history,
        input  ready
    );
    modport sink (
        input  valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4, clear_history,
        output ready
    );
endinterface

interface lfps_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_speed;
    logic [15:0] right_speed;
    logic [15:0] steer_correction;
    logic [11:0] line_offset;
    logic [2:0]  band_count;
    logic        all_dark;

    modport source (
        output valid, left_speed, right_speed, steer_correction, line_offset,
               band_count, all_dark,
        input  ready
    );
    modport sink (
        input  valid, left_speed, right_speed, steer_correction, line_offset,
               band_count, all_dark,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/lfps_datapath.sv]
// Datapath: centroid divider, error update, shared multiplier, output registers
`default_nettype none

module lfps_datapath (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire lfps_pkg::t_cmd                 i_cmd,
    output lfps_pkg::t_sts                      o_sts,
    input  wire [lfps_pkg::SENSOR_W-1:0]        i_sensor [lfps_pkg::N_SENSORS],
    input  wire                                 i_clear_history,
    input  wire                                 i_cfg_we,
    input  wire [lfps_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [lfps_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic [lfps_pkg::SPEED_W-1:0]        o_left_speed,
    output logic [lfps_pkg::SPEED_W-1:0]        o_right_speed,
    output logic [lfps_pkg::CORR_W-1:0]         o_steer_correction,
    output logic [lfps_pkg::OFFSET_W-1:0]       o_line_offset,
    output logic [lfps_pkg::COUNT_W-1:0]        o_band_count,
    output logic                                o_all_dark
);

    // configuration
    logic [lfps_pkg::GAIN_W-1:0]   r_kp, r_ki, r_kd;
    logic [lfps_pkg::SPEED_W-1:0]  r_base;
    logic [lfps_pkg::OFFSET_W-1:0] r_set_point;
    logic [lfps_pkg::SENSOR_W-1:0] r_band_high, r_band_low;

    // history
    logic [lfps_pkg::ESUM_W-1:0]   r_err_sum;
    logic [lfps_pkg::ERR_W-1:0]    r_last_err;

    // per-item working registers
    logic [lfps_pkg::SSUM_W-1:0]    r_sum;
    logic [lfps_pkg::DVD_W-1:0]     r_dvd;
    logic [lfps_pkg::SSUM_W-1:0]    r_rem;
    logic [lfps_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic                           r_neg, r_zero, r_clr;
    logic [lfps_pkg::COUNT_W-1:0]   r_count;
    logic                           r_dark;
    logic [lfps_pkg::OFFSET_W-1:0]  r_offset;
    logic [lfps_pkg::ERR_W-1:0]     r_error;
    logic [lfps_pkg::DIFF_W-1:0]    r_diff;
    logic signed [lfps_pkg::PROD_W-1:0] r_prod;
    logic [lfps_pkg::ACC_W-1:0]     r_acc;
    logic [lfps_pkg::CORR_W-1:0]    r_corr;

    // item intake
    logic [lfps_pkg::SENSOR_W-1:0] inv [lfps_pkg::N_SENSORS];
    logic [lfps_pkg::SSUM_W-1:0]   sum_in;
    logic [lfps_pkg::COUNT_W-1:0]  cnt_in;
    logic                          dark_in;
    logic [11:0]                   wsum_in;
    logic [lfps_pkg::SSUM_W-1:0]   abs_in;
    logic [lfps_pkg::DVD_W-1:0]    dvd_in;

    always_comb begin
        sum_in  = '0;
        cnt_in  = '0;
        dark_in = 1'b1;
        for (int k = 0; k < lfps_pkg::N_SENSORS; k++) begin
            inv[k] = 8'd255 - i_sensor[k];
            sum_in = sum_in + lfps_pkg::SSUM_W'(inv[k]);
            if (i_sensor[k] != '0 && i_sensor[k] < r_band_high
                    && i_sensor[k] > r_band_low) begin
                cnt_in = cnt_in + 3'd1;
            end
            if (i_sensor[k] >= lfps_pkg::DARK_LEVEL) begin
                dark_in = 1'b0;
            end
        end
    end

    // weights -2,-1,0,+1,+2
    assign wsum_in = ({3'b0, inv[4], 1'b0} - {3'b0, inv[0], 1'b0})
                   + ({4'b0, inv[3]} - {4'b0, inv[1]});
    assign abs_in  = wsum_in[11] ? lfps_pkg::SSUM_W'(-wsum_in) : wsum_in[10:0];
    // |wsum| * 640 = |wsum| * 512 + |wsum| * 128
    assign dvd_in  = {abs_in[9:0], 9'b0} + {2'b0, abs_in[9:0], 7'b0};

    // restoring division, one quotient bit a cycle
    logic [lfps_pkg::SSUM_W:0] rem_sh, rem_sub;
    logic                      ge;

    assign rem_sh  = {r_rem, r_dvd[lfps_pkg::DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_sum};
    assign ge      = rem_sh >= {1'b0, r_sum};
    assign o_sts.div_last = (r_div_cnt == lfps_pkg::DIV_LAST);

    // error and accumulator update
    logic [lfps_pkg::OFFSET_W-1:0] mag, offset_c;
    logic [lfps_pkg::ERR_W-1:0]    err_c, last_base;
    logic [lfps_pkg::ESUM_W-1:0]   es_base, es_next;
    logic [lfps_pkg::ESUM_W:0]     s33;
    logic [lfps_pkg::DIFF_W-1:0]   diff_c;

    always_comb begin
        mag       = {1'b0, r_dvd[lfps_pkg::QUOT_W-1:0]};
        offset_c  = r_zero ? '0 : (r_neg ? -mag : mag);
        err_c     = {r_set_point[lfps_pkg::OFFSET_W-1], r_set_point}
                  - {offset_c[lfps_pkg::OFFSET_W-1], offset_c};
        es_base   = r_clr ? '0 : r_err_sum;
        last_base = r_clr ? '0 : r_last_err;
        s33       = {es_base[lfps_pkg::ESUM_W-1], es_base}
                  + {{20{err_c[lfps_pkg::ERR_W-1]}}, err_c};
        if (s33[32] != s33[31]) begin
            es_next = s33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            es_next = s33[31:0];
        end
        diff_c    = {err_c[lfps_pkg::ERR_W-1], err_c}
                  - {last_base[lfps_pkg::ERR_W-1], last_base};
    end

    // shared multiplier: gain times error, error sum or error change
    logic [lfps_pkg::GAIN_W-1:0]         gain_sel;
    logic [lfps_pkg::ESUM_W-1:0]         opnd_sel;
    logic signed [lfps_pkg::PROD_W-1:0]  prod_c;

    always_comb begin
        unique case (i_cmd.mul_sel)
            lfps_pkg::MUL_P: begin
                gain_sel = r_kp;
                opnd_sel = {{19{r_error[lfps_pkg::ERR_W-1]}}, r_error};
            end
            lfps_pkg::MUL_I: begin
                gain_sel = r_ki;
                opnd_sel = r_err_sum;
            end
            lfps_pkg::MUL_D: begin
                gain_sel = r_kd;
                opnd_sel = {{18{r_diff[lfps_pkg::DIFF_W-1]}}, r_diff};
            end
            default: begin
                gain_sel = '0;
                opnd_sel = '0;
            end
        endcase
    end

    assign prod_c = $signed({1'b0, gain_sel}) * $signed(opnd_sel);

    // round to Q.8 by floor of (sum + 2^15) / 2^16, then saturate
    logic [lfps_pkg::ACC_W-1:0]  rnd_t;
    logic [41:0]                 sh;
    logic [lfps_pkg::CORR_W-1:0] corr_c;

    always_comb begin
        rnd_t = r_acc + lfps_pkg::RND_HALF;
        sh    = rnd_t[lfps_pkg::ACC_W-1:16];
        if ((&sh[41:15]) || !(|sh[41:15])) begin
            corr_c = sh[15:0];
        end else begin
            corr_c = sh[41] ? 16'h8000 : 16'h7FFF;
        end
    end

    // wheel speeds
    logic [17:0]                  l18, r18;
    logic [lfps_pkg::SPEED_W-1:0] left_c, right_c;

    always_comb begin
        l18 = {2'b0, r_base} - {{2{r_corr[15]}}, r_corr};
        r18 = {2'b0, r_base} + {{2{r_corr[15]}}, r_corr};
        if (l18[17]) begin
            left_c = '0;
        end else if (l18[16:0] > {1'b0, lfps_pkg::SPEED_MAX}) begin
            left_c = lfps_pkg::SPEED_MAX;
        end else begin
            left_c = l18[15:0];
        end
        if (r18[17]) begin
            right_c = '0;
        end else if (r18[16:0] > {1'b0, lfps_pkg::SPEED_MAX}) begin
            right_c = lfps_pkg::SPEED_MAX;
        end else begin
            right_c = r18[15:0];
        end
    end

    // configuration and history registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= lfps_pkg::RST_KP_GAIN;
            r_ki        <= lfps_pkg::RST_KI_DT_GAIN;
            r_kd        <= lfps_pkg::RST_KD_DT_GAIN;
            r_base      <= lfps_pkg::RST_BASE_SPEED;
            r_set_point <= lfps_pkg::RST_SET_POINT;
            r_band_high <= lfps_pkg::RST_BAND_HIGH;
            r_band_low  <= lfps_pkg::RST_BAND_LOW;
            r_err_sum   <= '0;
            r_last_err  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lfps_pkg::CFG_KP_GAIN:    r_kp        <= i_cfg_data;
                    lfps_pkg::CFG_KI_DT_GAIN: r_ki        <= i_cfg_data;
                    lfps_pkg::CFG_KD_DT_GAIN: r_kd        <= i_cfg_data;
                    lfps_pkg::CFG_BASE_SPEED: r_base      <= i_cfg_data[15:0];
                    lfps_pkg::CFG_SET_POINT:  r_set_point <= i_cfg_data[11:0];
                    lfps_pkg::CFG_BAND_HIGH:  r_band_high <= i_cfg_data[7:0];
                    lfps_pkg::CFG_BAND_LOW:   r_band_low  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.err_upd) begin
                r_err_sum  <= es_next;
                r_last_err <= err_c;
            end
        end
    end

    // working and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sum     <= sum_in;
            r_dvd     <= dvd_in;
            r_rem     <= '0;
            r_div_cnt <= '0;
            r_neg     <= wsum_in[11];
            r_zero    <= (sum_in == '0);
            r_clr     <= i_clear_history;
            r_count   <= cnt_in;
            r_dark    <= dark_in;
        end
        if (i_cmd.div_step) begin
            r_rem     <= ge ? rem_sub[lfps_pkg::SSUM_W-1:0] : rem_sh[lfps_pkg::SSUM_W-1:0];
            r_dvd     <= {r_dvd[lfps_pkg::DVD_W-2:0], ge};
            r_div_cnt <= r_div_cnt + 5'd1;
        end
        if (i_cmd.err_upd) begin
            r_offset <= offset_c;
            r_error  <= err_c;
            r_diff   <= diff_c;
            r_acc    <= '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod_c;
        end
        if (i_cmd.acc_en) begin
            r_acc <= r_acc + {r_prod[lfps_pkg::PROD_W-1], r_prod};
        end
        if (i_cmd.rnd) begin
            r_corr <= corr_c;
        end
        if (i_cmd.out_load) begin
            o_left_speed       <= left_c;
            o_right_speed      <= right_c;
            o_steer_correction <= r_corr;
            o_line_offset      <= r_offset;
            o_band_count       <= r_count;
            o_all_dark         <= r_dark;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lfps_ctrl.sv]
// Controller: sequences one item through the datapath and owns the handshakes
`default_nettype none
`include "line_follow_pid_steering_assert.svh"

module lfps_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output lfps_pkg::t_cmd        o_cmd,
    input  wire lfps_pkg::t_sts   i_sts
);

    lfps_pkg::t_state   r_state, n_state;
    lfps_pkg::t_mul_sel r_mcnt, n_mcnt;
    logic               r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfps_pkg::ST_IDLE;
            r_mcnt      <= lfps_pkg::MUL_P;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mcnt      <= n_mcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_mcnt        = r_mcnt;
        o_cmd         = '0;
        o_cmd.mul_sel = r_mcnt;
        unique case (r_state)
            lfps_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lfps_pkg::ST_DIV;
                end
            end
            lfps_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = lfps_pkg::ST_ERR;
                end
            end
            lfps_pkg::ST_ERR: begin
                o_cmd.err_upd = 1'b1;
                n_mcnt        = lfps_pkg::MUL_P;
                n_state       = lfps_pkg::ST_MUL;
            end
            lfps_pkg::ST_MUL: begin
                // fold the previous product while the next one forms
                o_cmd.mul_en = 1'b1;
                o_cmd.acc_en = (r_mcnt != lfps_pkg::MUL_P);
                unique case (r_mcnt)
                    lfps_pkg::MUL_P: n_mcnt = lfps_pkg::MUL_I;
                    lfps_pkg::MUL_I: n_mcnt = lfps_pkg::MUL_D;
                    default: begin
                        n_mcnt  = lfps_pkg::MUL_P;
                        n_state = lfps_pkg::ST_ACC;
                    end
                endcase
            end
            lfps_pkg::ST_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = lfps_pkg::ST_RND;
            end
            lfps_pkg::ST_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = lfps_pkg::ST_FIN;
            end
            lfps_pkg::ST_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = lfps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lfps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_ready  = (r_state == lfps_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    `LFPS_ASSERT_NEXT(a_accept_starts_div, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == lfps_pkg::ST_DIV, "accepted item did not start the division")
    `LFPS_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || i_out_ready, "result register overwritten while still held")
    `LFPS_ASSERT_NEXT(a_div_to_err, i_clk, i_rst_n, r_state == lfps_pkg::ST_DIV && i_sts.div_last, r_state == lfps_pkg::ST_ERR, "division did not end after its last step")
    `LFPS_ASSERT_IMPL(a_busy_not_ready, i_clk, i_rst_n, r_state != lfps_pkg::ST_IDLE, !o_in_ready, "item channel ready while an item is in work")

endmodule

`default_nettype wire

[hw/rtl/line_follow_pid_steering.sv]
// Top level of the line-follower steering block
//
// Usage:
//   i_item carries one sensor tick: five 8-bit reflectance samples (255 is
//   full white) and a clear_history flag that zeroes the error sum and the
//   previous error before the step. o_result carries one result item per
//   tick: left/right wheel speeds (Q8.8), the PID correction (Q.8), the line
//   offset (Q.8 over -5..5), the in-band sensor count and an all-dark flag.
//   Both channels use valid/ready; an item moves when both are high.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while
//   the block is idle; unknown indexes are dropped.
// Sequence:
//   o_result.valid rises after the item is accepted and has passed the
//   bit-serial centroid divider, one error update, the shared 25x32
//   multiplier and accumulator, one rounding step and the output load. One
//   item is in work at a time, so the next item is taken only after the
//   output load of the one before.
// Reset and stalls:
//   Reset restores the register defaults and clears the PID history. A
//   held result stays in the output register while the receiver stalls; the
//   next item is still accepted and worked, and waits before its output load.
`default_nettype none

module line_follow_pid_steering (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    lfps_item_if.sink                         i_item,
    lfps_result_if.source                     o_result,
    input  wire                               i_cfg_we,
    input  wire [lfps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [lfps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    lfps_pkg::t_cmd              cmd;
    lfps_pkg::t_sts              sts;
    logic [lfps_pkg::SENSOR_W-1:0] sensor [lfps_pkg::N_SENSORS];
    logic                        in_ready;
    logic                        out_valid;

    // gather the samples, leftmost first
    assign sensor[0] = i_item.sensor_0;
    assign sensor[1] = i_item.sensor_1;
    assign sensor[2] = i_item.sensor_2;
    assign sensor[3] = i_item.sensor_3;
    assign sensor[4] = i_item.sensor_4;

    lfps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    lfps_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_sensor           (sensor),
        .i_clear_history    (i_item.clear_history),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_left_speed       (o_result.left_speed),
        .o_right_speed      (o_result.right_speed),
        .o_steer_correction (o_result.steer_correction),
        .o_line_offset      (o_result.line_offset),
        .o_band_count       (o_result.band_count),
        .o_all_dark         (o_result.all_dark)
    );

    assign i_item.ready   = in_ready;
    assign o_result.valid = out_valid;

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the line-follower steering block
module testbench;
    import lfps_pkg::*;

    // Half clock period, run limit, the long receiver hold-off and the final drain
    localparam int CLK_HALF       = 6;
    localparam int CYCLE_LIMIT    = 400_000;
    localparam int RX_HOLD_CYCLES = 700;
    localparam int DRAIN_CYCLES   = 40;

    // Centroid scale: weight range of two maps onto an offset of five in Q.8
    localparam int    OFFSET_SCALE = 640;
    localparam longint ROUND_HALF  = 64'sd32768;
    localparam longint CORR_MIN    = -64'sd32768;
    localparam longint CORR_MAX    = 64'sd32767;
    localparam longint ESUM_MIN    = -64'sd2147483648;
    localparam longint ESUM_MAX    = 64'sd2147483647;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [N_SENSORS-1:0][SENSOR_W-1:0] sensor;
        logic                               clear_history;
    } tick_t;

    typedef struct packed {
        logic [SPEED_W-1:0]  left_speed;
        logic [SPEED_W-1:0]  right_speed;
        logic [CORR_W-1:0]   steer_correction;
        logic [OFFSET_W-1:0] line_offset;
        logic [COUNT_W-1:0]  band_count;
        logic                all_dark;
    } steer_result_t;

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    lfps_item_if   item_ch ();
    lfps_result_if result_ch ();

    line_follow_pid_steering dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Mirror of the configuration registers, kept in step with every write
    logic [GAIN_W-1:0]          cfg_kp;
    logic [GAIN_W-1:0]          cfg_ki_dt;
    logic [GAIN_W-1:0]          cfg_kd_dt;
    logic [SPEED_W-1:0]         cfg_base;
    logic signed [OFFSET_W-1:0] cfg_set_point;
    logic [SENSOR_W-1:0]        cfg_band_high;
    logic [SENSOR_W-1:0]        cfg_band_low;

    // PID history of the predictor
    int pid_err_sum;
    int pid_last_err;

    tick_t         tick_pending[$];
    steer_result_t steer_expected[$];

    int  error_count;
    int  cycle_count;
    int  tx_gap_left;
    int  rx_gap_left;
    int  rx_hold_left;
    bit  rx_hold_arm;
    bit  tx_idle_en;
    bit  rx_idle_en;
    tick_t         next_tick;
    tick_t         seen_tick;
    steer_result_t got_result;
    steer_result_t want_result;

    // Work out one steering step and advance the PID history
    function automatic steer_result_t predict_steer(tick_t t);
        steer_result_t r;
        int     inv_sum;
        int     wt_sum;
        int     inv;
        int     mag;
        int     offset;
        int     err;
        int     cnt;
        bit     dark;
        longint acc;
        longint prod_sum;
        longint corr;
        longint left;
        longint right;
        inv_sum = 0;
        wt_sum  = 0;
        cnt     = 0;
        dark    = 1'b1;
        for (int k = 0; k < N_SENSORS; k++) begin
            inv = 255 - int'(t.sensor[k]);
            inv_sum += inv;
            wt_sum  += (k - 2) * inv;
            if (t.sensor[k] != 0 && t.sensor[k] < cfg_band_high && t.sensor[k] > cfg_band_low)
                cnt++;
            if (t.sensor[k] >= DARK_LEVEL)
                dark = 1'b0;
        end
        // Clear the history before this step, not after
        if (t.clear_history) begin
            pid_err_sum  = 0;
            pid_last_err = 0;
        end
        // Zero inverted sum (all white): hold the offset at zero
        offset = 0;
        if (inv_sum != 0) begin
            mag    = (wt_sum < 0 ? -wt_sum : wt_sum) * OFFSET_SCALE / inv_sum;
            offset = wt_sum < 0 ? -mag : mag;
        end
        err = int'(cfg_set_point) - offset;
        acc = longint'(pid_err_sum) + err;
        if (acc < ESUM_MIN) acc = ESUM_MIN;
        if (acc > ESUM_MAX) acc = ESUM_MAX;
        pid_err_sum = int'(acc);
        prod_sum = longint'(cfg_kp) * err
                 + longint'(cfg_ki_dt) * pid_err_sum
                 + longint'(cfg_kd_dt) * (err - pid_last_err);
        corr = (prod_sum + ROUND_HALF) >>> 16;
        if (corr < CORR_MIN) corr = CORR_MIN;
        if (corr > CORR_MAX) corr = CORR_MAX;
        left  = longint'(cfg_base) - corr;
        right = longint'(cfg_base) + corr;
        if (left < 0) left = 0;
        if (left > longint'(SPEED_MAX)) left = longint'(SPEED_MAX);
        if (right < 0) right = 0;
        if (right > longint'(SPEED_MAX)) right = longint'(SPEED_MAX);
        pid_last_err = err;
        r.left_speed       = left[SPEED_W-1:0];
        r.right_speed      = right[SPEED_W-1:0];
        r.steer_correction = corr[CORR_W-1:0];
        r.line_offset      = offset[OFFSET_W-1:0];
        r.band_count       = cnt[COUNT_W-1:0];
        r.all_dark         = dark;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return $urandom_range(1, 3);
        if (r < 18) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Random tick: mostly a plausible line under the array, some noise and extremes
    function automatic tick_t make_tick();
        tick_t t;
        int    kind;
        int    centre;
        int    width;
        int    bright;
        int    sep;
        kind   = $urandom_range(0, 9);
        centre = $urandom_range(0, 4);
        width  = $urandom_range(0, 1);
        bright = $urandom_range(170, 255);
        for (int k = 0; k < N_SENSORS; k++) begin
            sep = k > centre ? k - centre : centre - k;
            if (kind < 7) begin
                if (sep <= width)
                    t.sensor[k] = 8'($urandom_range(0, 90));
                else
                    t.sensor[k] = 8'($urandom_range(bright - 30 < 0 ? 0 : bright - 30,
                                                    bright));
            end else if (kind < 9) begin
                t.sensor[k] = 8'($urandom_range(0, 255));
            end else begin
                t.sensor[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
        end
        t.clear_history = ($urandom_range(0, 15) == 0);
        return t;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic push_tick(logic [7:0] s0, logic [7:0] s1, logic [7:0] s2,
                             logic [7:0] s3, logic [7:0] s4, logic clr);
        tick_t t;
        t.sensor        = {s4, s3, s2, s1, s0};
        t.clear_history = clr;
        tick_pending.push_back(t);
    endtask

    // One register write per clock edge; mirror it at once, no item is in flight
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_KP_GAIN:    cfg_kp        = data[GAIN_W-1:0];
            CFG_KI_DT_GAIN: cfg_ki_dt     = data[GAIN_W-1:0];
            CFG_KD_DT_GAIN: cfg_kd_dt     = data[GAIN_W-1:0];
            CFG_BASE_SPEED: cfg_base      = data[SPEED_W-1:0];
            CFG_SET_POINT:  cfg_set_point = data[OFFSET_W-1:0];
            CFG_BAND_HIGH:  cfg_band_high = data[SENSOR_W-1:0];
            CFG_BAND_LOW:   cfg_band_low  = data[SENSOR_W-1:0];
            default: ;
        endcase
    endtask

    // Write every register, junk in the unused upper data bits, plus the unmapped index
    task automatic apply_config(logic [23:0] kp, logic [23:0] ki, logic [23:0] kd,
                                logic [15:0] base, logic [11:0] sp,
                                logic [7:0] band_hi, logic [7:0] band_lo);
        cfg_write(CFG_KP_GAIN, kp);
        cfg_write(CFG_KI_DT_GAIN, ki);
        cfg_write(CFG_KD_DT_GAIN, kd);
        cfg_write(CFG_BASE_SPEED, {8'($urandom), base});
        cfg_write(CFG_SET_POINT, {12'($urandom), sp});
        cfg_write(CFG_BAND_HIGH, {16'($urandom), band_hi});
        cfg_write(CFG_BAND_LOW, {16'($urandom), band_lo});
        cfg_write(CFG_UNMAPPED, 24'($urandom));
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom);
            default: return 24'($urandom_range(0, 24'h040000));
        endcase
    endfunction

    task automatic apply_random_config();
        logic [15:0] base;
        logic [11:0] sp;
        logic [7:0]  lo;
        logic [7:0]  hi;
        case ($urandom_range(0, 4))
            0:       base = 16'hFFFF;
            1:       base = 16'($urandom_range(16'hFF01, 16'hFFFF));
            2:       base = 16'($urandom);
            default: base = 16'($urandom_range(0, 16'h4000));
        endcase
        if ($urandom_range(0, 3) == 0)
            sp = 12'($urandom);
        else
            sp = 12'($urandom_range(0, 2560) - 1280);
        lo = 8'($urandom_range(0, 120));
        hi = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(lo, 255));
        apply_config(pick_gain(), pick_gain(), pick_gain(), base, sp, hi, lo);
    endtask

    // Wait until every queued item has gone in and every result has come out
    task automatic wait_drained();
        do @(negedge i_clk);
        while (tick_pending.size() != 0 || item_ch.valid || steer_expected.size() != 0);
    endtask

    task automatic run_random(int n, bit tx_idle, bit rx_idle);
        @(negedge i_clk);
        tx_idle_en = tx_idle;
        rx_idle_en = rx_idle;
        repeat (n) tick_pending.push_back(make_tick());
        wait_drained();
        // Let the block settle before the next register write
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Cycle counter and run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Driver: offer queued items, hold each until taken, insert random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            tx_gap_left   <= 0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                seen_tick.sensor = {item_ch.sensor_4, item_ch.sensor_3, item_ch.sensor_2,
                                    item_ch.sensor_1, item_ch.sensor_0};
                seen_tick.clear_history = item_ch.clear_history;
                steer_expected.push_back(predict_steer(seen_tick));
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (tx_gap_left != 0) begin
                    item_ch.valid <= 1'b0;
                    tx_gap_left   <= tx_gap_left - 1;
                end else if (tick_pending.size() != 0) begin
                    next_tick = tick_pending.pop_front();
                    item_ch.valid         <= 1'b1;
                    item_ch.sensor_0      <= next_tick.sensor[0];
                    item_ch.sensor_1      <= next_tick.sensor[1];
                    item_ch.sensor_2      <= next_tick.sensor[2];
                    item_ch.sensor_3      <= next_tick.sensor[3];
                    item_ch.sensor_4      <= next_tick.sensor[4];
                    item_ch.clear_history <= next_tick.clear_history;
                    // Pick the idle stretch that follows this item
                    if (tx_idle_en && $urandom_range(0, 2) == 0)
                        tx_gap_left <= pick_gap();
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the driver keeps offering items
    always @(posedge i_clk) begin
        if (!i_rst_n)
            rx_hold_left <= 0;
        else if (rx_hold_arm)
            rx_hold_left <= RX_HOLD_CYCLES;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // Monitor: check each result against the oldest prediction, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            rx_gap_left     <= 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                got_result.left_speed       = result_ch.left_speed;
                got_result.right_speed      = result_ch.right_speed;
                got_result.steer_correction = result_ch.steer_correction;
                got_result.line_offset      = result_ch.line_offset;
                got_result.band_count       = result_ch.band_count;
                got_result.all_dark         = result_ch.all_dark;
                if (steer_expected.size() == 0) begin
                    report_mismatch("result item with no prediction waiting");
                end else begin
                    want_result = steer_expected.pop_front();
                    check_field("left_speed", got_result.left_speed, want_result.left_speed);
                    check_field("right_speed", got_result.right_speed,
                                want_result.right_speed);
                    check_field("steer_correction", got_result.steer_correction,
                                want_result.steer_correction);
                    check_field("line_offset", 16'(got_result.line_offset),
                                16'(want_result.line_offset));
                    check_field("band_count", 16'(got_result.band_count),
                                16'(want_result.band_count));
                    check_field("all_dark", 16'(got_result.all_dark),
                                16'(want_result.all_dark));
                end
            end
            if (rx_hold_left != 0) begin
                result_ch.ready <= 1'b0;
            end else if (rx_gap_left != 0) begin
                result_ch.ready <= 1'b0;
                rx_gap_left     <= rx_gap_left - 1;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                result_ch.ready <= 1'b0;
                rx_gap_left     <= pick_gap() - 1;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        // Drive every input to a known value from time zero
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = '0;
        cfg_data              = '0;
        item_ch.valid         = 1'b0;
        item_ch.sensor_0      = '0;
        item_ch.sensor_1      = '0;
        item_ch.sensor_2      = '0;
        item_ch.sensor_3      = '0;
        item_ch.sensor_4      = '0;
        item_ch.clear_history = 1'b0;
        result_ch.ready       = 1'b0;
        rx_hold_arm           = 1'b0;
        tx_idle_en            = 1'b1;
        rx_idle_en            = 1'b1;
        error_count           = 0;
        cycle_count           = 0;
        pid_err_sum           = 0;
        pid_last_err          = 0;
        cfg_kp                = RST_KP_GAIN;
        cfg_ki_dt             = RST_KI_DT_GAIN;
        cfg_kd_dt             = RST_KD_DT_GAIN;
        cfg_base              = RST_BASE_SPEED;
        cfg_set_point         = RST_SET_POINT;
        cfg_band_high         = RST_BAND_HIGH;
        cfg_band_low          = RST_BAND_LOW;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks under the reset settings
        @(negedge i_clk);
        push_tick(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1); // all white: zero sum
        push_tick(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0); // all black
        push_tick(8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 1'b0); // line under each sensor
        push_tick(8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 1'b0);
        push_tick(8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 1'b0);
        push_tick(8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 1'b0);
        push_tick(8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   1'b0);
        push_tick(8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 1'b0); // extreme left
        push_tick(8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   1'b0); // extreme right
        push_tick(8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   1'b1); // symmetric, clear
        push_tick(8'd51,  8'd52,  8'd127, 8'd128, 8'd1,   1'b0); // band edges
        push_tick(8'd101, 8'd102, 8'd101, 8'd101, 8'd101, 1'b0); // one at dark level
        push_tick(8'd101, 8'd101, 8'd101, 8'd101, 8'd101, 1'b0); // all just dark
        push_tick(8'd50,  8'd127, 8'd129, 8'd255, 8'd0,   1'b0);
        push_tick(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
        push_tick(8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  1'b0);
        push_tick(8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55,  1'b1);
        push_tick(8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0); // tiny sum, far left
        push_tick(8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 1'b0); // tiny sum, far right
        push_tick(8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   1'b0);
        wait_drained();
        repeat (4) @(posedge i_clk);

        // Gains at full scale, base above the speed ceiling, set point off the top
        apply_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 12'h7FF, 8'd255, 8'd0);
        run_random(40, 1'b1, 1'b1);

        // Everything at zero, set point off the bottom, band empty
        apply_config(24'd0, 24'd0, 24'd0, 16'd0, 12'h800, 8'd0, 8'd255);
        run_random(40, 1'b1, 1'b1);

        // Receiver holds off for a long stretch while the sender keeps offering
        apply_random_config();
        @(negedge i_clk);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        @(posedge i_clk);
        rx_hold_arm <= 1'b1;
        @(posedge i_clk);
        rx_hold_arm <= 1'b0;
        @(negedge i_clk);
        repeat (30) tick_pending.push_back(make_tick());
        // Sender pauses here until every result has come back
        wait_drained();
        repeat (20) tick_pending.push_back(make_tick());
        wait_drained();
        repeat (4) @(posedge i_clk);

        // Random settings; one phase runs with no idling on either side
        apply_random_config();
        run_random(45, 1'b0, 1'b0);
        for (int ph = 0; ph < 5; ph++) begin
            apply_random_config();
            run_random(45, 1'b1, 1'b1);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (steer_expected.size() != 0)
            report_mismatch("predictions left over at the end");
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
